FILE: hdl/hrw_pkg.sv
// ----------------------------------------------------------------------------
// hrw_pkg
// Shared types and constants for the height map ray walkability check.
// ----------------------------------------------------------------------------
package hrw_pkg;

    // map geometry defaults
    localparam int MAP_WIDTH_DEF  = 256;
    localparam int MAP_HEIGHT_DEF = 256;

    // fixed point format and sampling
    localparam int FRAC_BITS    = 16;
    localparam int SAMPLE_SHIFT = 5;
    localparam int SAMPLE_STEPS = 1 << SAMPLE_SHIFT;

    // store geometry
    localparam int ADDR_W = 16;
    localparam int WORD_W = 24;

    // datapath widths
    localparam int COORD_W = 32;
    localparam int POS_W   = 34;            // sample point, may exceed 32 bits slightly
    localparam int DIFF_W  = POS_W + 1;     // origin minus sample point
    localparam int LO_W    = 17;            // low slice of the magnitude
    localparam int HI_W    = DIFF_W - LO_W;
    localparam int PROD_W  = DIFF_W + COORD_W;
    localparam int Q_W     = PROD_W - 2 * FRAC_BITS;

    // commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE  = 2'd3;

    // configuration reset values
    localparam logic signed [COORD_W-1:0] ORIGIN_RST = 32'sd0;
    localparam logic signed [COORD_W-1:0] SCALE_RST  = 32'sd65536;

    // one command transfer
    typedef struct packed {
        logic                      cmd;
        logic [ADDR_W-1:0]         map_index;
        logic [WORD_W-1:0]         map_word;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
        logic [30:0]               climb_limit;
    } t_item;

    // one result transfer
    typedef struct packed {
        logic                      blocked;
        logic signed [COORD_W-1:0] stop_x;
        logic signed [COORD_W-1:0] stop_y;
        logic signed [COORD_W-1:0] stop_z;
    } t_result;

endpackage

FILE: hdl/hrw_to_pixel.sv
// ----------------------------------------------------------------------------
// hrw_to_pixel
// Five stage mapping of a world coordinate to a clamped pixel index.
// ----------------------------------------------------------------------------
module hrw_to_pixel #(
    parameter int SIZE = hrw_pkg::MAP_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic signed [hrw_pkg::COORD_W-1:0]   i_origin,
    input  logic signed [hrw_pkg::COORD_W-1:0]   i_scale,
    input  logic signed [hrw_pkg::POS_W-1:0]     i_pos,
    output logic [$clog2(SIZE)-1:0]              o_pix
);

    localparam int PIX_W = $clog2(SIZE);

    logic signed [hrw_pkg::DIFF_W-1:0] r_diff;
    logic [hrw_pkg::DIFF_W-1:0]        r_mag;
    logic [hrw_pkg::COORD_W-1:0]       r_smag;
    logic                              r_neg_b;
    logic [hrw_pkg::LO_W+hrw_pkg::COORD_W-1:0] r_lo;
    logic [hrw_pkg::HI_W+hrw_pkg::COORD_W-1:0] r_hi;
    logic                              r_neg_c;
    logic [hrw_pkg::Q_W-1:0]           r_q;
    logic                              r_neg_d;
    logic [PIX_W-1:0]                  r_pix;

    logic [hrw_pkg::PROD_W-1:0]        n_prod;

    // stage a: offset from the origin
    always_ff @(posedge i_clk) begin
        r_diff <= hrw_pkg::DIFF_W'(i_origin) - hrw_pkg::DIFF_W'(i_pos);
    end

    // stage b: magnitudes and sign of the product
    always_ff @(posedge i_clk) begin
        r_mag   <= r_diff[hrw_pkg::DIFF_W-1] ? hrw_pkg::DIFF_W'(-r_diff)
                                             : hrw_pkg::DIFF_W'(r_diff);
        r_smag  <= i_scale[hrw_pkg::COORD_W-1] ? hrw_pkg::COORD_W'(-i_scale)
                                               : hrw_pkg::COORD_W'(i_scale);
        r_neg_b <= r_diff[hrw_pkg::DIFF_W-1] != i_scale[hrw_pkg::COORD_W-1];
    end

    // stage c: two partial products
    always_ff @(posedge i_clk) begin
        r_lo    <= {{hrw_pkg::COORD_W{1'b0}}, r_mag[hrw_pkg::LO_W-1:0]}
                 * {{hrw_pkg::LO_W{1'b0}}, r_smag};
        r_hi    <= {{hrw_pkg::COORD_W{1'b0}}, r_mag[hrw_pkg::DIFF_W-1:hrw_pkg::LO_W]}
                 * {{hrw_pkg::HI_W{1'b0}}, r_smag};
        r_neg_c <= r_neg_b;
    end

    // stage d: sum partials, drop the fraction bits of both factors
    always_comb begin
        n_prod = hrw_pkg::PROD_W'(r_lo) + (hrw_pkg::PROD_W'(r_hi) << hrw_pkg::LO_W);
    end

    always_ff @(posedge i_clk) begin
        r_q     <= n_prod[hrw_pkg::PROD_W-1:2*hrw_pkg::FRAC_BITS];
        r_neg_d <= r_neg_c;
    end

    // stage e: clamp to the map edges
    always_ff @(posedge i_clk) begin
        if (r_neg_d) begin
            r_pix <= '0;
        end else if (r_q >= hrw_pkg::Q_W'(SIZE)) begin
            r_pix <= PIX_W'(SIZE - 1);
        end else begin
            r_pix <= r_q[PIX_W-1:0];
        end
    end

    assign o_pix = r_pix;

endmodule

FILE: hdl/heightmap_ray_walkability_check.sv
// ----------------------------------------------------------------------------
// heightmap_ray_walkability_check
// Height map store with a pipelined ray march and climb limit check.
// ----------------------------------------------------------------------------
// A write command (cmd 0) stores one map word in the cycle it is taken and
// leaves busy low, so commands may follow back to back. A check command
// (cmd 1) raises busy: 33 samples leave the step generator one per cycle,
// each passes five pixel mapping stages, one registered read of the
// 64K-word map memory and one compare stage, and the result strobe
// o_res_valid comes in the cycle after the deciding sample. A blocked ray
// ends the check early. The memory read port serves one sample per cycle
// and sets the sample rate. The receiver cannot stall: o_result is valid
// only during the cycle in which o_res_valid is high.
// Map entries never written read back undefined heights.
// ----------------------------------------------------------------------------
module heightmap_ray_walkability_check #(
    parameter int MAP_WIDTH  = hrw_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = hrw_pkg::MAP_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  hrw_pkg::t_item                    i_item,
    output logic                              o_res_valid,
    output hrw_pkg::t_result                  o_result,
    input  logic                              i_cfg_we,
    input  logic [hrw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hrw_pkg::COORD_W-1:0]       i_cfg_data
);

    localparam int COL_W = $clog2(MAP_WIDTH);
    localparam int ROW_W = $clog2(MAP_HEIGHT);
    localparam int CNT_W = hrw_pkg::SAMPLE_SHIFT + 1;
    localparam int LAT   = 7;
    localparam int SUM_W = hrw_pkg::POS_W + 2;
    localparam int MEM_DEPTH = 1 << hrw_pkg::ADDR_W;

    typedef struct packed {
        logic                            first;
        logic                            last;
        logic signed [hrw_pkg::POS_W-1:0] x;
        logic signed [hrw_pkg::POS_W-1:0] y;
        logic signed [hrw_pkg::POS_W-1:0] z;
    } t_tag;

    // configuration registers
    logic signed [hrw_pkg::COORD_W-1:0] r_x_origin;
    logic signed [hrw_pkg::COORD_W-1:0] r_y_origin;
    logic signed [hrw_pkg::COORD_W-1:0] r_x_scale;
    logic signed [hrw_pkg::COORD_W-1:0] r_y_scale;

    // step generator
    logic                               r_gen_on;
    logic [CNT_W-1:0]                   r_cnt;
    logic signed [hrw_pkg::POS_W-1:0]   r_px;
    logic signed [hrw_pkg::POS_W-1:0]   r_py;
    logic signed [hrw_pkg::POS_W-1:0]   r_pz;
    logic signed [hrw_pkg::POS_W-1:0]   r_dx;
    logic signed [hrw_pkg::POS_W-1:0]   r_dy;
    logic signed [hrw_pkg::POS_W-1:0]   r_dz;
    logic signed [hrw_pkg::COORD_W-1:0] r_ex;
    logic signed [hrw_pkg::COORD_W-1:0] r_ey;
    logic signed [hrw_pkg::COORD_W-1:0] r_ez;
    logic [30:0]                        r_limit;

    // sample pipeline
    logic [LAT-1:0]                     r_vld;
    t_tag                               r_tag [LAT];
    logic [COL_W-1:0]                   w_col;
    logic [ROW_W-1:0]                   w_row;
    logic [hrw_pkg::ADDR_W-1:0]         w_rd_addr;
    logic [hrw_pkg::WORD_W-1:0]         r_mem [MEM_DEPTH];
    logic [hrw_pkg::WORD_W-1:0]         r_word;
    logic signed [SUM_W-1:0]            r_sum;

    // result
    logic                               r_res_valid;
    hrw_pkg::t_result                   r_result;

    logic                               w_take;
    logic                               w_take_chk;
    logic                               w_take_wr;
    logic                               w_over;
    logic                               w_emit;
    t_tag                               w_tag_in;
    logic signed [hrw_pkg::COORD_W:0]   w_dx_full;
    logic signed [hrw_pkg::COORD_W:0]   w_dy_full;
    logic signed [hrw_pkg::COORD_W:0]   w_dz_full;
    logic [31:0]                        w_mag;
    logic                               w_red;
    logic signed [SUM_W-1:0]            w_mag_s;
    logic signed [SUM_W-1:0]            w_pz_s;
    logic signed [SUM_W-1:0]            w_lim_s;
    t_tag                               w_last_tag;

    // command transfer
    assign busy       = r_gen_on | (|r_vld);
    assign w_take     = start & ~busy;
    assign w_take_chk = w_take & (i_item.cmd == hrw_pkg::CMD_CHECK);
    assign w_take_wr  = w_take & (i_item.cmd == hrw_pkg::CMD_WRITE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin <= hrw_pkg::ORIGIN_RST;
            r_y_origin <= hrw_pkg::ORIGIN_RST;
            r_x_scale  <= hrw_pkg::SCALE_RST;
            r_y_scale  <= hrw_pkg::SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hrw_pkg::REG_X_ORIGIN: r_x_origin <= i_cfg_data;
                hrw_pkg::REG_Y_ORIGIN: r_y_origin <= i_cfg_data;
                hrw_pkg::REG_X_SCALE:  r_x_scale  <= i_cfg_data;
                hrw_pkg::REG_Y_SCALE:  r_y_scale  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // step vector, floor of the span over the sample count
    assign w_dx_full = (hrw_pkg::COORD_W+1)'(i_item.end_x) - (hrw_pkg::COORD_W+1)'(i_item.start_x);
    assign w_dy_full = (hrw_pkg::COORD_W+1)'(i_item.end_y) - (hrw_pkg::COORD_W+1)'(i_item.start_y);
    assign w_dz_full = (hrw_pkg::COORD_W+1)'(i_item.end_z) - (hrw_pkg::COORD_W+1)'(i_item.start_z);

    // step generator control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_on <= 1'b0;
            r_cnt    <= '0;
        end else if (w_take_chk) begin
            r_gen_on <= 1'b1;
            r_cnt    <= '0;
        end else if (w_emit) begin
            r_gen_on <= 1'b0;
        end else if (r_gen_on) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(hrw_pkg::SAMPLE_STEPS)) begin
                r_gen_on <= 1'b0;
            end
        end
    end

    // step generator datapath
    always_ff @(posedge i_clk) begin
        if (w_take_chk) begin
            r_px    <= hrw_pkg::POS_W'(i_item.start_x);
            r_py    <= hrw_pkg::POS_W'(i_item.start_y);
            r_pz    <= hrw_pkg::POS_W'(i_item.start_z);
            r_dx    <= hrw_pkg::POS_W'(w_dx_full >>> hrw_pkg::SAMPLE_SHIFT);
            r_dy    <= hrw_pkg::POS_W'(w_dy_full >>> hrw_pkg::SAMPLE_SHIFT);
            r_dz    <= hrw_pkg::POS_W'(w_dz_full >>> hrw_pkg::SAMPLE_SHIFT);
            r_ex    <= i_item.end_x;
            r_ey    <= i_item.end_y;
            r_ez    <= i_item.end_z;
            r_limit <= i_item.climb_limit;
        end else if (r_gen_on) begin
            r_px <= r_px + r_dx;
            r_py <= r_py + r_dy;
            r_pz <= r_pz + r_dz;
        end
    end

    // sample tag entering the pipeline
    always_comb begin
        w_tag_in.first = (r_cnt == '0);
        w_tag_in.last  = (r_cnt == CNT_W'(hrw_pkg::SAMPLE_STEPS));
        w_tag_in.x     = r_px;
        w_tag_in.y     = r_py;
        w_tag_in.z     = r_pz;
    end

    // valid bits of the pipeline, flushed once a result is decided
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_emit) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], r_gen_on};
        end
    end

    // tag shift line
    always_ff @(posedge i_clk) begin
        r_tag[0] <= w_tag_in;
        for (int k = 1; k < LAT; k++) begin
            r_tag[k] <= r_tag[k-1];
        end
    end

    // column and row mapping
    hrw_to_pixel #(
        .SIZE (MAP_WIDTH)
    ) u_col (
        .i_clk    (i_clk),
        .i_origin (r_x_origin),
        .i_scale  (r_x_scale),
        .i_pos    (r_px),
        .o_pix    (w_col)
    );

    hrw_to_pixel #(
        .SIZE (MAP_HEIGHT)
    ) u_row (
        .i_clk    (i_clk),
        .i_origin (r_y_origin),
        .i_scale  (r_y_scale),
        .i_pos    (r_py),
        .o_pix    (w_row)
    );

    // read address, wraps to the store size
    always_comb begin
        logic [31:0] v_addr;
        v_addr    = 32'(w_row) * 32'(MAP_WIDTH) + 32'(w_col);
        w_rd_addr = v_addr[hrw_pkg::ADDR_W-1:0];
    end

    // map memory: write on a write transfer, registered read per sample
    always_ff @(posedge i_clk) begin
        if (w_take_wr) begin
            r_mem[i_item.map_index] <= i_item.map_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= r_mem[w_rd_addr];
    end

    // height against sample z; |h - z| equals |mag + z| or |mag - z|
    assign w_red   = (r_word[23:16] != 8'd0);
    assign w_mag   = 32'({r_word[15:0], {hrw_pkg::FRAC_BITS{1'b0}}});
    assign w_mag_s = SUM_W'({1'b0, w_mag});
    assign w_pz_s  = SUM_W'(r_tag[LAT-2].z);

    always_ff @(posedge i_clk) begin
        r_sum <= w_red ? (w_mag_s + w_pz_s) : (w_mag_s - w_pz_s);
    end

    // decision on the oldest sample
    assign w_last_tag = r_tag[LAT-1];
    assign w_lim_s    = SUM_W'({1'b0, r_limit});
    assign w_over     = (r_sum > w_lim_s) || (r_sum < -w_lim_s);
    assign w_emit     = r_vld[LAT-1] & (w_over | w_last_tag.last);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_result.blocked <= w_over;
            if (!w_over) begin
                r_result.stop_x <= r_ex;
                r_result.stop_y <= r_ey;
                r_result.stop_z <= r_ez;
            end else if (w_last_tag.first) begin
                r_result.stop_x <= w_last_tag.x[hrw_pkg::COORD_W-1:0];
                r_result.stop_y <= w_last_tag.y[hrw_pkg::COORD_W-1:0];
                r_result.stop_z <= w_last_tag.z[hrw_pkg::COORD_W-1:0];
            end else begin
                r_result.stop_x <= hrw_pkg::COORD_W'(w_last_tag.x - r_dx);
                r_result.stop_y <= hrw_pkg::COORD_W'(w_last_tag.y - r_dy);
                r_result.stop_z <= hrw_pkg::COORD_W'(w_last_tag.z - r_dz);
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

`ifndef SYNTH
    // a check keeps the block busy until its result
    a_chk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take_chk |=> busy)
        else $error("check transfer did not raise busy");

    // a map write completes in its own cycle
    a_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take_wr |=> !busy)
        else $error("map write left the block busy");

    // the result strobe comes with the pipeline flushed
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("result while samples still in flight");

    // one result per check
    a_one_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe longer than one cycle");

    // sample counter stays within the ray
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen_on |-> (r_cnt <= CNT_W'(hrw_pkg::SAMPLE_STEPS)))
        else $error("sample counter ran past the end point");
`endif

endmodule

FILE: tb/tb_heightmap_ray_walkability_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heightmap_ray_walkability_check
// Self-checking bench for the height map ray walkability check. The whole map
// is filled first so no sample ever reads an unset entry. A short directed
// table follows, then random writes and ray checks under several register
// settings. Every check without a typed result is marched by a local
// predictor; each result strobe is compared against the oldest predicted walk.
// ----------------------------------------------------------------------------
module tb_heightmap_ray_walkability_check;

    import hrw_pkg::*;

    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE_CYCLES = 64;
    localparam int          NUM_PHASES    = 7;
    localparam int          ITEMS_PER_PH  = 286;
    localparam int          REGION_PX     = 26;
    localparam longint      REACH_CAP     = 64'h7FFF_FFFF;

    typedef struct {
        t_item   it;
        bit      typed;
        t_result res;
    } dir_row_t;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     start      = 1'b0;
    logic                     busy;
    t_item                    i_item     = '0;
    logic                     o_res_valid;
    t_result                  o_result;
    logic                     i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx  = '0;
    logic [COORD_W-1:0]       i_cfg_data = '0;

    // local copy of the map and the mapping registers
    logic [WORD_W-1:0]        height_map [0:(1 << ADDR_W) - 1];
    longint                   cfg_x_origin = 0;
    longint                   cfg_y_origin = 0;
    longint                   cfg_x_scale  = 65536;
    longint                   cfg_y_scale  = 65536;

    t_result                  walk_outcomes_q [$];
    dir_row_t                 dir_rows [$];
    int unsigned              n_fail    = 0;
    int unsigned              cycle_cnt = 0;

    heightmap_ray_walkability_check u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // world coordinate to clamped pixel index, exact wide product
    function automatic int unsigned pixel_of(input longint origin, input longint pos,
                                             input longint scale, input int unsigned size);
        longint          d;
        longint unsigned mag_d;
        longint unsigned mag_s;
        longint unsigned q;
        d     = origin - pos;
        mag_d = (d < 0) ? -d : d;
        mag_s = (scale < 0) ? -scale : scale;
        q     = (mag_d * mag_s) >> (2 * FRAC_BITS);
        if (q == 0 || ((d < 0) != (scale < 0))) return 0;
        if (q >= size) return size - 1;
        return int'(q);
    endfunction

    // signed terrain height under a sample point
    function automatic longint terrain_height(input longint x, input longint y);
        int unsigned       col;
        int unsigned       row;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] word;
        longint            h;
        col  = pixel_of(cfg_x_origin, x, cfg_x_scale, MAP_WIDTH_DEF);
        row  = pixel_of(cfg_y_origin, y, cfg_y_scale, MAP_HEIGHT_DEF);
        addr = ADDR_W'(row * MAP_WIDTH_DEF + col);
        word = height_map[addr];
        h    = longint'({48'd0, word[15:0]}) << FRAC_BITS;
        if (word[23:16] != 8'd0) h = -h;
        return h;
    endfunction

    // march the ray sample by sample and report where it stops
    function automatic t_result march_ray(input t_item it);
        longint  sx, sy, sz, ex, ey, ez;
        longint  stx, sty, stz;
        longint  px, py, pz;
        longint  lim;
        longint  gap_h;
        int      i;
        t_result res;
        sx  = longint'($signed(it.start_x));
        sy  = longint'($signed(it.start_y));
        sz  = longint'($signed(it.start_z));
        ex  = longint'($signed(it.end_x));
        ey  = longint'($signed(it.end_y));
        ez  = longint'($signed(it.end_z));
        lim = longint'({33'd0, it.climb_limit});
        // floor division by the sample count
        stx = (ex - sx) >>> SAMPLE_SHIFT;
        sty = (ey - sy) >>> SAMPLE_SHIFT;
        stz = (ez - sz) >>> SAMPLE_SHIFT;
        res.blocked = 1'b0;
        res.stop_x  = it.end_x;
        res.stop_y  = it.end_y;
        res.stop_z  = it.end_z;
        for (i = 0; i <= SAMPLE_STEPS; i++) begin
            px    = sx + i * stx;
            py    = sy + i * sty;
            pz    = sz + i * stz;
            gap_h = terrain_height(px, py) - pz;
            if (gap_h < 0) gap_h = -gap_h;
            if (gap_h > lim) begin
                // stop at the previous sample, or at the start itself
                if (i > 0) begin
                    px -= stx;
                    py -= sty;
                    pz -= stz;
                end
                res.blocked = 1'b1;
                res.stop_x  = px[31:0];
                res.stop_y  = py[31:0];
                res.stop_z  = pz[31:0];
                return res;
            end
        end
        return res;
    endfunction

    function automatic t_item check_cmd(input logic [31:0] sx, sy, sz, ex, ey, ez,
                                        input logic [30:0] lim);
        t_item it;
        it             = '0;
        it.cmd         = CMD_CHECK;
        it.start_x     = sx;
        it.start_y     = sy;
        it.start_z     = sz;
        it.end_x       = ex;
        it.end_y       = ey;
        it.end_z       = ez;
        it.climb_limit = lim;
        return it;
    endfunction

    function automatic t_item write_cmd(input logic [ADDR_W-1:0] idx,
                                        input logic [WORD_W-1:0] w);
        t_item it;
        it           = '0;
        it.cmd       = CMD_WRITE;
        it.map_index = idx;
        it.map_word  = w;
        return it;
    endfunction

    function automatic t_result walk_to(input logic b, input logic [31:0] x, y, z);
        t_result res;
        res.blocked = b;
        res.stop_x  = x;
        res.stop_y  = y;
        res.stop_z  = z;
        return res;
    endfunction

    // coordinate landing a few pixels around pixel zero for the given mapping
    function automatic logic [31:0] near_map(input longint origin, input longint scale);
        longint mag;
        longint reach;
        longint off;
        longint pos;
        mag   = (scale < 0) ? -scale : scale;
        reach = (mag == 0) ? REACH_CAP : (longint'(REGION_PX) << 32) / mag;
        if (reach > REACH_CAP) reach = REACH_CAP;
        off = longint'($urandom_range(0, 32'(reach))) - reach / 16;
        if (scale < 0) off = -off;
        pos = origin - off;
        return pos[31:0];
    endfunction

    // random command: mostly region writes and region rays, some noise
    function automatic t_item random_item();
        t_item       it;
        int unsigned pick;
        longint      z;
        it.cmd         = CMD_CHECK;
        it.map_index   = $urandom;
        it.map_word    = $urandom;
        it.start_x     = $urandom;
        it.start_y     = $urandom;
        it.start_z     = $urandom;
        it.end_x       = $urandom;
        it.end_y       = $urandom;
        it.end_z       = $urandom;
        it.climb_limit = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            it.cmd                = CMD_WRITE;
            it.map_index          = {8'($urandom_range(0, REGION_PX + 1)),
                                     8'($urandom_range(0, REGION_PX + 1))};
            it.map_word[15:8]     = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00;
            it.map_word[23:16]    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
        end else if (pick < 40) begin
            it.cmd = CMD_WRITE;
        end else if (pick < 92) begin
            it.start_x = near_map(cfg_x_origin, cfg_x_scale);
            it.start_y = near_map(cfg_y_origin, cfg_y_scale);
            it.end_x   = near_map(cfg_x_origin, cfg_x_scale);
            it.end_y   = near_map(cfg_y_origin, cfg_y_scale);
            z          = longint'($urandom_range(0, 300 << 16)) - (40 << 16);
            it.start_z = z[31:0];
            z          = longint'($urandom_range(0, 300 << 16)) - (40 << 16);
            it.end_z   = z[31:0];
            case ($urandom_range(0, 9))
                0:       it.climb_limit = '0;
                1:       it.climb_limit = $urandom;
                default: it.climb_limit = $urandom_range(0, 80 << 16);
            endcase
        end
        return it;
    endfunction

    // one command transfer, then record what it should do
    task automatic send(input t_item it, input int gap, input bit drain,
                        input bit typed, input t_result typed_res);
        int idle;
        idle = (drain && gap == 0) ? 1 : gap;
        if (idle > 0) begin
            start <= 1'b0;
            repeat (idle) @(posedge i_clk);
            while (drain && walk_outcomes_q.size() != 0) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (it.cmd == CMD_WRITE)
            height_map[it.map_index] = it.map_word;
        else
            walk_outcomes_q.push_back(typed ? typed_res : march_ray(it));
    endtask

    // wait for every walk, then let a write still in flight finish
    task automatic settle();
        start <= 1'b0;
        while (walk_outcomes_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_X_ORIGIN: cfg_x_origin = longint'($signed(val));
            REG_Y_ORIGIN: cfg_y_origin = longint'($signed(val));
            REG_X_SCALE:  cfg_x_scale  = longint'($signed(val));
            REG_Y_SCALE:  cfg_y_scale  = longint'($signed(val));
        endcase
    endtask

    task automatic program_regs(input logic [31:0] x0, y0, xs, ys);
        write_reg(REG_X_ORIGIN, x0);
        write_reg(REG_Y_ORIGIN, y0);
        write_reg(REG_X_SCALE, xs);
        write_reg(REG_Y_SCALE, ys);
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string field, input logic [31:0] want, got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
            n_fail++;
        end
    endtask

    // compare each result transfer with the oldest predicted walk
    always @(posedge i_clk) begin : walk_check
        t_result want;
        if (i_rst_n && o_res_valid) begin
            if (walk_outcomes_q.size() == 0) begin
                $display("%0t: unexpected result transfer: got %p", $time, o_result);
                n_fail++;
            end else begin
                want = walk_outcomes_q.pop_front();
                check_field("blocked", want.blocked, o_result.blocked);
                check_field("stop_x", want.stop_x, o_result.stop_x);
                check_field("stop_y", want.stop_y, o_result.stop_y);
                check_field("stop_z", want.stop_z, o_result.stop_z);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: run limit reached", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // main sequence
    initial begin : stimulus
        t_item       it;
        t_result     no_res;
        logic [31:0] phase_set [NUM_PHASES][4];
        bit          burst;
        int          p;
        int          k;
        no_res = '0;
        burst  = 1'b0;
        phase_set = '{
            '{32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000},
            '{32'h0003_0000, 32'hFFFE_0000, 32'h0004_0000, 32'h0002_0000},
            '{32'hFFF6_0000, 32'h0007_0000, 32'hFFFF_0000, 32'hFFFD_0000},
            '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
            '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001},
            '{32'h0, 32'h0, 32'h0, 32'h0},
            '{32'h0, 32'h0, 32'h0, 32'h0}
        };
        for (p = 5; p < NUM_PHASES; p++) begin
            phase_set[p][0] = $urandom;
            phase_set[p][1] = $urandom;
            phase_set[p][2] = $urandom_range(32'h8000, 32'h8_0000);
            phase_set[p][3] = $urandom_range(32'h8000, 32'h8_0000);
            if ($urandom_range(0, 1)) phase_set[p][2] = -phase_set[p][2];
            if ($urandom_range(0, 1)) phase_set[p][3] = -phase_set[p][3];
        end
        for (k = 0; k < (1 << ADDR_W); k++) height_map[k] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole map with flat ground, back to back
        for (k = 0; k < (1 << ADDR_W); k++)
            send(write_cmd(ADDR_W'(k), '0), 0, 1'b0, 1'b0, no_res);

        // directed rows on flat ground with reset mapping
        dir_rows.push_back('{check_cmd(0, 0, 0, 0, 0, 0, 0), 1'b1, walk_to(0, 0, 0, 0)});
        // blocked at the very first sample
        dir_rows.push_back('{check_cmd(32'hFFFB_0000, 32'hFFFD_0000, 32'h0001_0000,
                                       32'hFFEC_0000, 32'hFFF7_0000, 32'h0, 31'd0),
                             1'b1, walk_to(1, 32'hFFFB_0000, 32'hFFFD_0000, 32'h0001_0000)});
        dir_rows.push_back('{check_cmd(32'h8000_0000, 32'h8000_0000, 32'h0,
                                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 31'd0),
                             1'b1, walk_to(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0)});
        dir_rows.push_back('{check_cmd(32'h0003_0000, 32'h0004_0000, 32'h8000_0000,
                                       32'h0010_0000, 32'h0, 32'h7FFF_FFFF, '1),
                             1'b1, walk_to(1, 32'h0003_0000, 32'h0004_0000, 32'h8000_0000)});
        // samples step past 32 bits on the way
        dir_rows.push_back('{check_cmd(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                       32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1),
                             1'b1, walk_to(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF)});
        // writes with the ray fields loaded with ones
        it = write_cmd(16'h0000, 24'hFF_FFFF);
        it.start_x = '1; it.start_y = '1; it.start_z = '1;
        it.end_x = '1; it.end_y = '1; it.end_z = '1; it.climb_limit = '1;
        dir_rows.push_back('{it, 1'b0, no_res});
        dir_rows.push_back('{write_cmd(16'h0001, 24'h00_0005), 1'b0, no_res});
        dir_rows.push_back('{write_cmd(16'hFFFF, 24'h00_FFFF), 1'b0, no_res});
        dir_rows.push_back('{write_cmd(16'h00FF, 24'h80_0100), 1'b0, no_res});
        // checks with map fields loaded with ones
        it = check_cmd(0, 0, 0, 32'hFFFC_0000, 0, 0, 31'h0001_0000);
        it.map_index = '1; it.map_word = '1;
        dir_rows.push_back('{it, 1'b0, no_res});
        dir_rows.push_back('{check_cmd(32'hFFFF_0000, 0, 32'h0005_0000,
                                       32'hFFFD_0000, 0, 0, 31'h0000_8000), 1'b0, no_res});
        dir_rows.push_back('{check_cmd(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                       32'h8000_0000, 32'h8000_0000, 32'h0, '1), 1'b0, no_res});
        dir_rows.push_back('{check_cmd(32'h8000_0000, 0, 32'hFF00_0000,
                                       32'h8000_0000, 0, 32'hFF00_0000, 31'd0), 1'b0, no_res});
        dir_rows.push_back('{check_cmd(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF, 31'd0), 1'b0, no_res});
        dir_rows.push_back('{check_cmd(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0,
                                       32'h0040_0000, 31'h0100_0000), 1'b0, no_res});
        dir_rows.push_back('{check_cmd(32'hFFFE_8000, 32'h0, 32'h0000_0000,
                                       32'hFFFE_8000, 32'hFFFF_0000, 32'h0006_0000,
                                       31'h0001_0000), 1'b0, no_res});
        foreach (dir_rows[k])
            send(dir_rows[k].it, $urandom_range(0, 14), 1'b0,
                 dir_rows[k].typed, dir_rows[k].res);

        // random part, one register setting per phase
        for (p = 0; p < NUM_PHASES; p++) begin
            settle();
            program_regs(phase_set[p][0], phase_set[p][1], phase_set[p][2], phase_set[p][3]);
            for (k = 0; k < ITEMS_PER_PH; k++) begin
                if (k % 40 == 0) burst = ($urandom_range(0, 3) == 0);
                send(random_item(), burst ? 0 : $urandom_range(0, 14),
                     $urandom_range(0, 127) == 0, 1'b0, no_res);
            end
        end

        settle();
        if (n_fail == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
hdl/hrw_pkg.sv
hdl/hrw_to_pixel.sv
hdl/heightmap_ray_walkability_check.sv
tb/tb_heightmap_ray_walkability_check.sv
